### hdl/lusf_pkg.sv
`timescale 1ns / 1ps

package lusf_pkg;

  // Fixed field widths of the ports
  localparam int CFG_W      = 7;
  localparam int SIDE_OUT_W = 7;
  localparam int POS_OUT_W  = 6;

  // Matrix side after reset
  localparam logic [CFG_W-1:0] CFG_SIDE_RESET = 7'd64;

  // Per-cell control from the scan stage to the best-square tracker
  typedef struct packed {
    logic fire;       // a cell is transferred this cycle
    logic frame_end;  // that cell is the last one of the matrix
    logic restart;    // side length rewritten, drop the matrix in progress
  } lusf_ctl_t;

endpackage

### hdl/lusf_ram.sv
`timescale 1ns / 1ps

module lusf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/lusf_scan.sv
`timescale 1ns / 1ps

module lusf_scan #(
  parameter int MAX_SIDE = 64,
  parameter int CW       = $clog2(MAX_SIDE),
  parameter int SW       = $clog2(MAX_SIDE + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lusf_pkg::CFG_W-1:0] cfg_side,
  input  logic                       fire,
  input  logic                       cell_bit,
  output lusf_pkg::lusf_ctl_t        ctl,
  output logic [SW-1:0]              cell_side,
  output logic [CW-1:0]              cell_row,
  output logic [CW-1:0]              cell_col
);

  import lusf_pkg::*;

  logic [CFG_W-1:0] side_length_r;
  logic [CW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             left_bit_r;
  logic [SW-1:0]    left_side_r;
  logic             diag_bit_r;
  logic [SW-1:0]    diag_side_r;
  logic [SW-1:0]    n_eff;
  logic             col_last, row_last;
  logic [SW:0]      lb_rdata, lb_wdata;
  logic             up_bit;
  logic [SW-1:0]    up_side;
  logic             grow;
  logic [SW-1:0]    min_ul, min_all, side;

  // Effective side: zero acts as one, clamp at MAX_SIDE
  always_comb begin
    if (side_length_r == '0) begin
      n_eff = SW'(1);
    end else if (int'(side_length_r) > MAX_SIDE) begin
      n_eff = SW'(MAX_SIDE);
    end else begin
      n_eff = SW'(side_length_r);
    end
  end

  assign col_last = (SW'(col_r) + SW'(1)) == n_eff;
  assign row_last = (SW'(row_r) + SW'(1)) == n_eff;

  // Previous-row line buffer: {bit, side} per column
  assign up_bit   = lb_rdata[SW];
  assign up_side  = lb_rdata[SW-1:0];
  assign lb_wdata = {cell_bit, side};

  // Side of the largest uniform square ending at this cell
  assign grow    = (row_r != '0) && (col_r != '0) && (up_bit == cell_bit) &&
                   (left_bit_r == cell_bit) && (diag_bit_r == cell_bit);
  assign min_ul  = (up_side < left_side_r) ? up_side : left_side_r;
  assign min_all = (min_ul < diag_side_r) ? min_ul : diag_side_r;
  assign side    = grow ? (min_all + SW'(1)) : SW'(1);

  // Scan position of the next cell
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_we) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (fire) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : (row_r + CW'(1));
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_length_r <= CFG_SIDE_RESET;
      row_r         <= '0;
      col_r         <= '0;
    end else begin
      if (cfg_we) begin
        side_length_r <= cfg_side;
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Left and upper-left neighbors
  always_ff @(posedge clk) begin
    if (fire) begin
      left_bit_r  <= cell_bit;
      left_side_r <= side;
      diag_bit_r  <= up_bit;
      diag_side_r <= up_side;
    end
  end

  // Read address follows the next cell's column, so data is ready on arrival
  lusf_ram #(
    .WIDTH(SW + 1),
    .DEPTH(MAX_SIDE)
  ) u_line (
    .clk  (clk),
    .we   (fire),
    .waddr(col_r),
    .wdata(lb_wdata),
    .raddr(col_nxt),
    .rdata(lb_rdata)
  );

  assign ctl.fire      = fire;
  assign ctl.frame_end = col_last && row_last;
  assign ctl.restart   = cfg_we;
  assign cell_side     = side;
  assign cell_row      = row_r;
  assign cell_col      = col_r;

endmodule

### hdl/lusf_best.sv
`timescale 1ns / 1ps

module lusf_best #(
  parameter int MAX_SIDE = 64,
  parameter int CW       = $clog2(MAX_SIDE),
  parameter int SW       = $clog2(MAX_SIDE + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lusf_pkg::lusf_ctl_t            ctl,
  input  logic [SW-1:0]                  cell_side,
  input  logic [CW-1:0]                  cell_row,
  input  logic [CW-1:0]                  cell_col,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [lusf_pkg::SIDE_OUT_W-1:0] out_square_side,
  output logic [lusf_pkg::POS_OUT_W-1:0]  out_corner_row,
  output logic [lusf_pkg::POS_OUT_W-1:0]  out_corner_col,
  output logic                           free
);

  import lusf_pkg::*;

  logic [SW-1:0]         best_side_r, best_side_nxt;
  logic [CW-1:0]         best_row_r, best_row_nxt;
  logic [CW-1:0]         best_col_r, best_col_nxt;
  logic                  out_valid_r;
  logic [SIDE_OUT_W-1:0] side_out_r;
  logic [POS_OUT_W-1:0]  row_out_r, col_out_r;
  logic                  take;

  // Ties go to the later corner
  assign take          = cell_side >= best_side_r;
  assign best_side_nxt = take ? cell_side : best_side_r;
  assign best_row_nxt  = take ? cell_row  : best_row_r;
  assign best_col_nxt  = take ? cell_col  : best_col_r;

  // Output register frees up when it is empty or drained this cycle
  assign free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_side_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.restart || (ctl.fire && ctl.frame_end)) begin
        best_side_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else if (ctl.fire) begin
        best_side_r <= best_side_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
      end
      if (ctl.fire && ctl.frame_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: corner moved from bottom-right to top-left
  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.frame_end) begin
      side_out_r <= SIDE_OUT_W'(best_side_nxt);
      row_out_r  <= POS_OUT_W'(32'(best_row_nxt) + 32'd1 - 32'(best_side_nxt));
      col_out_r  <= POS_OUT_W'(32'(best_col_nxt) + 32'd1 - 32'(best_side_nxt));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_square_side = side_out_r;
  assign out_corner_row  = row_out_r;
  assign out_corner_col  = col_out_r;

endmodule

### hdl/largest_uniform_square_finder.sv
`timescale 1ns / 1ps
// The result is registered and valid on out_ in the cycle after the last cell's transfer.
// Throughput: one cell per cycle when input is not stalled; the previous-row line buffer
// is read ahead at the next column, so the per-cell path is a 3-way min and compare.
// A pending result stalls input only while out_ready is low.
// Reset (rst_n low, synchronous): side length 64, scan at row 0 column 0,
// no result pending; line buffer contents need no clearing.

module largest_uniform_square_finder #(
  parameter int MAX_SIDE = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lusf_pkg::CFG_W-1:0]      cfg_side_length,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cell_bit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lusf_pkg::SIDE_OUT_W-1:0] out_square_side,
  output logic [lusf_pkg::POS_OUT_W-1:0]  out_corner_row,
  output logic [lusf_pkg::POS_OUT_W-1:0]  out_corner_col
);

  import lusf_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);

  lusf_ctl_t     ctl;
  logic [SW-1:0] cell_side;
  logic [CW-1:0] cell_row;
  logic [CW-1:0] cell_col;
  logic          free;
  logic          fire;

  // Configuration writes always complete
  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign fire      = in_valid && free;

  lusf_scan #(
    .MAX_SIDE(MAX_SIDE)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_side (cfg_side_length),
    .fire     (fire),
    .cell_bit (in_cell_bit),
    .ctl      (ctl),
    .cell_side(cell_side),
    .cell_row (cell_row),
    .cell_col (cell_col)
  );

  lusf_best #(
    .MAX_SIDE(MAX_SIDE)
  ) u_best (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .cell_side      (cell_side),
    .cell_row       (cell_row),
    .cell_col       (cell_col),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_square_side(out_square_side),
    .out_corner_row (out_corner_row),
    .out_corner_col (out_corner_col),
    .free           (free)
  );

endmodule

### hdl/lusf_checker.sv
`timescale 1ns / 1ps

module lusf_checker #(
  parameter int MAX_SIDE = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lusf_pkg::SIDE_OUT_W-1:0] out_square_side,
  input logic [lusf_pkg::POS_OUT_W-1:0]  out_corner_row,
  input logic [lusf_pkg::POS_OUT_W-1:0]  out_corner_col
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_square_side) &&
    $stable(out_corner_row) && $stable(out_corner_col))
    else $error("result changed while stalled");

  // No cell is taken while a finished result waits and cannot leave
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output register full");

  // Every reported square has at least one cell
  a_side_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_square_side != '0)
    else $error("empty square reported");

  // The square stays within 64 rows and 64 columns (checked when MAX_SIDE is at most 64)
  a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n || MAX_SIDE > 64)
    out_valid |-> ((8'(out_corner_row) + 8'(out_square_side)) <= 8'd64) &&
    ((8'(out_corner_col) + 8'(out_square_side)) <= 8'd64))
    else $error("square runs past the matrix edge");

endmodule

bind largest_uniform_square_finder lusf_checker #(.MAX_SIDE(MAX_SIDE)) u_lusf_checker (.*);
